[rtl/spa_pkg.sv]
// Package for the sparse polynomial adder: store depth, index widths,
// action codes, state machine states and the transaction payload structs.
// No dependencies.
package spa_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_LOAD_A = 2'd0,
        ACT_LOAD_B = 2'd1,
        ACT_RUN    = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_MERGE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] term_coef;
        logic [15:0]        term_exp;
    } t_in_item;

    typedef struct packed {
        logic signed [32:0] sum_coef;
        logic [15:0]        sum_exp;
        logic               last;
        logic               empty_res;
        logic               overflow;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] coef;
        logic [15:0]        exp;
    } t_term;

    typedef struct packed {
        logic [CNT_W-1:0] count_a;
        logic [CNT_W-1:0] count_b;
        logic             dropped;
    } t_store_stat;

    typedef struct packed {
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
        logic             clear;
    } t_store_cmd;

endpackage

[rtl/spa_store.sv]
// Term store: a DEPTH-entry memory of (coefficient, exponent) terms with a
// fill count and a registered read port. Depends on spa_pkg.
module spa_store (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  spa_pkg::t_term        i_wr_term,
    input  logic                  i_clear,
    input  logic [spa_pkg::IDX_W-1:0] i_rd_idx,
    output spa_pkg::t_term        o_rd_term,
    output logic [spa_pkg::CNT_W-1:0] o_count,
    output logic                  o_full
);
    import spa_pkg::*;

    t_term            r_mem [DEPTH];
    t_term            r_rd_term;
    logic [CNT_W-1:0] r_count;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_count   = r_count;
    assign o_rd_term = r_rd_term;

    // Writes land at the fill count; the caller never writes a full store.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= i_wr_term;
        end
        r_rd_term <= r_mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_clear) begin
            r_count <= '0;
        end else if (i_wr_en) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

endmodule

[rtl/spa_ctrl.sv]
// Merge sequencer: walks both term stores with one shared compare and
// 33-bit add unit, holds one term back to place the last mark, and drives
// the output register. Depends on spa_pkg.
module spa_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  spa_pkg::t_store_stat i_stat,
    input  spa_pkg::t_term       i_rd_a,
    input  spa_pkg::t_term       i_rd_b,
    output spa_pkg::t_store_cmd  o_cmd,
    output logic                 o_busy,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output spa_pkg::t_out_item   o_out_item
);
    import spa_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] r_j;
    t_out_item        r_hold;
    logic             r_hold_valid;
    t_out_item        r_out;
    logic             r_out_valid;

    logic               a_ok;
    logic               b_ok;
    logic               use_a;
    logic               use_b;
    logic               done;
    logic               produce;
    logic               out_free;
    logic               step_ok;
    logic               fin_ok;
    logic signed [32:0] sum;
    logic [15:0]        cand_exp;
    t_out_item          final_item;

    // Shared unit: exponent compare and one 33-bit add per merge step.
    always_comb begin
        a_ok     = (r_i < i_stat.count_a);
        b_ok     = (r_j < i_stat.count_b);
        use_a    = a_ok && (!b_ok || (i_rd_a.exp >= i_rd_b.exp));
        use_b    = b_ok && (!a_ok || (i_rd_b.exp >= i_rd_a.exp));
        sum      = (use_a ? {i_rd_a.coef[31], i_rd_a.coef} : 33'sd0)
                 + (use_b ? {i_rd_b.coef[31], i_rd_b.coef} : 33'sd0);
        cand_exp = use_a ? i_rd_a.exp : i_rd_b.exp;
        done     = !a_ok && !b_ok;
        // Paired terms that cancel are dropped.
        produce  = !done && !(use_a && use_b && (sum == 33'sd0));
        out_free = !r_out_valid || i_out_ready;
        step_ok  = (r_state == S_MERGE) && !done
                 && (!produce || !r_hold_valid || out_free);
        fin_ok   = (r_state == S_FINISH) && out_free;
    end

    always_comb begin
        if (r_hold_valid) begin
            final_item      = r_hold;
            final_item.last = 1'b1;
        end else begin
            final_item           = '0;
            final_item.last      = 1'b1;
            final_item.empty_res = 1'b1;
            final_item.overflow  = i_stat.dropped;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_start) n_state = S_FETCH;
            S_FETCH:  n_state = S_MERGE;
            S_MERGE: begin
                if (done) begin
                    n_state = S_FINISH;
                end else if (step_ok) begin
                    n_state = S_FETCH;
                end
            end
            S_FINISH: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_busy       = (r_state != S_IDLE);
        o_cmd.idx_a  = r_i[IDX_W-1:0];
        o_cmd.idx_b  = r_j[IDX_W-1:0];
        o_cmd.clear  = fin_ok;
        o_out_valid  = r_out_valid;
        o_out_item   = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_i          <= '0;
            r_j          <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_start && (r_state == S_IDLE)) begin
                r_i <= '0;
                r_j <= '0;
            end else if (step_ok) begin
                if (use_a) r_i <= r_i + CNT_W'(1);
                if (use_b) r_j <= r_j + CNT_W'(1);
            end
            if (step_ok && produce) begin
                r_hold_valid <= 1'b1;
            end else if (fin_ok) begin
                r_hold_valid <= 1'b0;
            end
            if ((step_ok && produce && r_hold_valid) || fin_ok) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_ok && produce) begin
            r_hold.sum_coef  <= sum;
            r_hold.sum_exp   <= cand_exp;
            r_hold.last      <= 1'b0;
            r_hold.empty_res <= 1'b0;
            r_hold.overflow  <= i_stat.dropped;
        end
        if (fin_ok) begin
            r_out <= final_item;
        end else if (step_ok && produce && r_hold_valid) begin
            r_out <= r_hold;
        end
    end

endmodule

[rtl/sparse_polynomial_adder.sv]
// Top level of the sparse polynomial adder: input decode, overflow flag,
// two term stores and the merge sequencer. Depends on spa_pkg, spa_store
// and spa_ctrl.
//
// Usage: each input transaction carries an action. A load action appends
// one (coefficient, exponent) term to the first or second term store; it
// produces no result. Each list is expected
// in descending exponent order. A load into a full store is dropped and sets
// an overflow flag that every result of the next run reports. A run action
// merges the two lists and emits the sum term by term on the output
// channel, with last set on the final transaction; if the sum has no terms,
// one transaction with empty_res and last set is emitted. The run then
// empties both stores and clears the overflow flag. Action code 3 is
// accepted and ignored.
//
// Timing: the input is not ready while a run is in progress. Each merge step
// of a run goes through a store read state, then a compare/add state through
// the shared unit, where a step takes one term from either list or an
// equal-exponent pair from both. One result is held back so the last mark
// can be placed; a stalled receiver holds the output register and the
// sequencer simply waits. Synchronous reset empties both stores, clears the
// overflow flag and returns to idle.
module sparse_polynomial_adder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spa_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spa_pkg::t_out_item o_out_item
);
    import spa_pkg::*;

    logic        busy;
    logic        in_accept;
    logic        load_a;
    logic        load_b;
    logic        start;
    logic        full_a;
    logic        full_b;
    logic        r_dropped;
    t_term       wr_term;
    t_term       rd_a;
    t_term       rd_b;
    t_store_stat stat;
    t_store_cmd  cmd;

    assign o_in_ready   = !busy;
    assign in_accept    = i_in_valid && !busy;
    assign wr_term.coef = i_in_item.term_coef;
    assign wr_term.exp  = i_in_item.term_exp;

    // Decode the action of an accepted transaction.
    always_comb begin
        load_a = 1'b0;
        load_b = 1'b0;
        start  = 1'b0;
        if (in_accept) begin
            unique case (i_in_item.action)
                ACT_LOAD_A: load_a = 1'b1;
                ACT_LOAD_B: load_b = 1'b1;
                ACT_RUN:    start  = 1'b1;
                default:    ;
            endcase
        end
    end

    // The overflow flag latches any dropped load until the run finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dropped <= 1'b0;
        end else if (cmd.clear) begin
            r_dropped <= 1'b0;
        end else if ((load_a && full_a) || (load_b && full_b)) begin
            r_dropped <= 1'b1;
        end
    end

    assign stat.dropped = r_dropped;

    spa_store u_store_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (load_a && !full_a),
        .i_wr_term (wr_term),
        .i_clear   (cmd.clear),
        .i_rd_idx  (cmd.idx_a),
        .o_rd_term (rd_a),
        .o_count   (stat.count_a),
        .o_full    (full_a)
    );

    spa_store u_store_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (load_b && !full_b),
        .i_wr_term (wr_term),
        .i_clear   (cmd.clear),
        .i_rd_idx  (cmd.idx_b),
        .o_rd_term (rd_b),
        .o_count   (stat.count_b),
        .o_full    (full_b)
    );

    spa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_stat      (stat),
        .i_rd_a      (rd_a),
        .i_rd_b      (rd_b),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

[test/sparse_polynomial_adder_checker.sv]
// Checker for the sparse polynomial adder: watches both channels, keeps its own copy of the
// two term lists and of the overflow flag, predicts every result term and compares them.
// Depends on spa_pkg for the payload structs, the action codes and DEPTH.
module sparse_polynomial_adder_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  spa_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  spa_pkg::t_out_item i_out_item,
    output int                 o_pending,
    output int                 o_fail_count
);

    spa_pkg::t_term     first_store[$];
    spa_pkg::t_term     second_store[$];
    logic               load_dropped = 1'b0;
    spa_pkg::t_out_item sum_terms_due[$];
    int                 fail_total = 0;

    function automatic logic signed [32:0] widen(input logic signed [31:0] coef);
        return {coef[31], coef};
    endfunction

    function automatic spa_pkg::t_out_item sum_term(input logic signed [32:0] coef,
                                                    input logic [15:0] term_exp);
        spa_pkg::t_out_item term;
        term           = '0;
        term.sum_coef  = coef;
        term.sum_exp   = term_exp;
        term.overflow  = load_dropped;
        return term;
    endfunction

    // Merge both lists by descending exponent, the way the block walks its stores.
    task automatic predict_sum();
        int                    i;
        int                    j;
        logic signed [32:0]    total;
        spa_pkg::t_out_item    run_terms[$];
        spa_pkg::t_out_item    tail;
        i = 0;
        j = 0;
        while (i < first_store.size() && j < second_store.size()) begin
            if (first_store[i].exp > second_store[j].exp) begin
                run_terms.push_back(sum_term(widen(first_store[i].coef), first_store[i].exp));
                i++;
            end else if (first_store[i].exp < second_store[j].exp) begin
                run_terms.push_back(sum_term(widen(second_store[j].coef), second_store[j].exp));
                j++;
            end else begin
                total = widen(first_store[i].coef) + widen(second_store[j].coef);
                // Paired terms that cancel leave nothing behind.
                if (total != 0)
                    run_terms.push_back(sum_term(total, first_store[i].exp));
                i++;
                j++;
            end
        end
        while (i < first_store.size()) begin
            run_terms.push_back(sum_term(widen(first_store[i].coef), first_store[i].exp));
            i++;
        end
        while (j < second_store.size()) begin
            run_terms.push_back(sum_term(widen(second_store[j].coef), second_store[j].exp));
            j++;
        end
        if (run_terms.size() == 0) begin
            tail           = sum_term('0, '0);
            tail.empty_res = 1'b1;
            run_terms.push_back(tail);
        end
        tail      = run_terms.pop_back();
        tail.last = 1'b1;
        run_terms.push_back(tail);
        foreach (run_terms[k])
            sum_terms_due.push_back(run_terms[k]);
        first_store.delete();
        second_store.delete();
        load_dropped = 1'b0;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        spa_pkg::t_out_item want;
        spa_pkg::t_term     term;
        if (!i_rst_n) begin
            first_store.delete();
            second_store.delete();
            sum_terms_due.delete();
            load_dropped = 1'b0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (sum_terms_due.size() == 0) begin
                    $error("unexpected result transaction: sum_coef %0d sum_exp %0d",
                           i_out_item.sum_coef, i_out_item.sum_exp);
                    fail_total++;
                end else begin
                    want = sum_terms_due.pop_front();
                    check_field("sum_coef", want.sum_coef, i_out_item.sum_coef);
                    check_field("sum_exp", want.sum_exp, i_out_item.sum_exp);
                    check_field("last", want.last, i_out_item.last);
                    check_field("empty_res", want.empty_res, i_out_item.empty_res);
                    check_field("overflow", want.overflow, i_out_item.overflow);
                end
            end
            if (i_in_valid && i_in_ready) begin
                term.coef = i_in_item.term_coef;
                term.exp  = i_in_item.term_exp;
                case (i_in_item.action)
                    spa_pkg::ACT_LOAD_A: begin
                        if (first_store.size() < spa_pkg::DEPTH)
                            first_store.push_back(term);
                        else
                            load_dropped = 1'b1;
                    end
                    spa_pkg::ACT_LOAD_B: begin
                        if (second_store.size() < spa_pkg::DEPTH)
                            second_store.push_back(term);
                        else
                            load_dropped = 1'b1;
                    end
                    spa_pkg::ACT_RUN: begin
                        predict_sum();
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending    <= sum_terms_due.size();
        o_fail_count <= fail_total;
    end

endmodule

[test/sparse_polynomial_adder_test.sv]
// Top of the sparse polynomial adder testbench: clock, reset, stimulus on the input channel,
// a randomly stalling receiver and the final verdict.
// Depends on spa_pkg, sparse_polynomial_adder and sparse_polynomial_adder_checker.
module sparse_polynomial_adder_test;

    // The unused action code is accepted and ignored by the block.
    localparam logic [1:0] ACT_IGNORED  = 2'd3;
    localparam int         RANDOM_ITEMS = 460;
    localparam int         HOLD_CYCLES  = 400;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    spa_pkg::t_in_item  in_item     = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    spa_pkg::t_out_item out_item;
    int                 pending;
    int                 fail_count;

    // Counts every transaction that the block acts on; ignored codes are left out.
    int                 items_sent  = 0;
    // While steady is set, neither side inserts any gap.
    bit                 steady      = 1'b0;
    // Requests to the receiver to hold off for a long stretch; each one is served once.
    int                 hold_req    = 0;

    sparse_polynomial_adder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    sparse_polynomial_adder_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The slowest correct run stays far below this; reaching it means the block hung.
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Coefficients lean toward the extremes, zero and small values.
    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom;
        endcase
    endfunction

    // Offer one transaction after a random gap and hold it until the block takes it.
    // Valid is only lowered when a gap follows, so back-to-back transactions keep it high.
    task automatic send(input logic [1:0] act, input logic [31:0] coef,
                        input logic [15:0] term_exp);
        int                gap;
        spa_pkg::t_in_item item;
        gap            = pick_gap();
        item.action    = act;
        item.term_coef = coef;
        item.term_exp  = term_exp;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
        if (act != ACT_IGNORED)
            items_sent++;
    endtask

    task automatic send_run();
        send(spa_pkg::ACT_RUN, $urandom, 16'($urandom));
    endtask

    // Build two well-formed lists by walking the exponent downward. At each exponent the
    // term goes to the first list (mode 0), the second (mode 1) or both (mode 2); a negative
    // mode picks one at random. Pairs often cancel; with cancel_all, all but a most negative pair do.
    // The loads of the two lists are interleaved at random, then a run usually follows.
    task automatic send_sum_case(input int steps, input int kind_mode, input bit cancel_all);
        spa_pkg::t_term first_terms[$];
        spa_pkg::t_term second_terms[$];
        spa_pkg::t_term a;
        spa_pkg::t_term b;
        int             e;
        int             kind;
        int             stride;
        e      = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535);
        stride = $urandom_range(0, 1) ? 3 : 4000;
        for (int k = 0; k < steps && e >= 0; k++) begin
            kind   = (kind_mode < 0) ? $urandom_range(0, 2) : kind_mode;
            a.coef = rand_coef();
            a.exp  = e[15:0];
            b.exp  = e[15:0];
            b.coef = (cancel_all || $urandom_range(0, 2) == 0) ? -a.coef : rand_coef();
            if (kind != 1)
                first_terms.push_back(a);
            if (kind != 0)
                second_terms.push_back(b);
            e -= $urandom_range(1, stride);
        end
        while (first_terms.size() + second_terms.size() > 0) begin
            if (second_terms.size() == 0 ||
                (first_terms.size() != 0 && $urandom_range(0, 1) == 1)) begin
                a = first_terms.pop_front();
                send(spa_pkg::ACT_LOAD_A, a.coef, a.exp);
            end else begin
                b = second_terms.pop_front();
                send(spa_pkg::ACT_LOAD_B, b.coef, b.exp);
            end
        end
        // Skipping the run now and then lets the next case append to unsorted lists.
        if ($urandom_range(0, 19) != 0)
            send_run();
    endtask

    // Noise: any action with arbitrary fields, so exponents come unsorted or duplicated.
    task automatic send_noise();
        int count;
        count = $urandom_range(1, 8);
        repeat (count)
            send(2'($urandom_range(0, 3)), $urandom, 16'($urandom_range(0, 65535)));
    endtask

    // The receiver: bursts of ready separated by random stalls. When asked, it holds off for
    // a long stretch, counted here, so that a run fills the block and the input stalls.
    initial begin
        int stall;
        int holds_served;
        holds_served = 0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_req != holds_served) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_served++;
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int random_start;
        int seq;
        int roll;
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A run on empty stores gives the single empty transaction.
        send_run();

        // Extreme coefficients and exponents: the largest sum at the top exponent, a pair
        // that cancels, a zero coefficient with no partner that must pass through, an
        // ignored action code in the middle, and the most negative sum at exponent zero.
        send(spa_pkg::ACT_LOAD_A, 32'h7FFF_FFFF, 16'd65535);
        send(spa_pkg::ACT_LOAD_B, 32'h7FFF_FFFF, 16'd65535);
        send(spa_pkg::ACT_LOAD_A, 32'd5, 16'd100);
        send(spa_pkg::ACT_LOAD_B, -32'sd5, 16'd100);
        send(spa_pkg::ACT_LOAD_A, 32'd0, 16'd50);
        send(ACT_IGNORED, $urandom, 16'($urandom));
        send(spa_pkg::ACT_LOAD_B, 32'd7, 16'd10);
        send(spa_pkg::ACT_LOAD_A, 32'h8000_0000, 16'd0);
        send(spa_pkg::ACT_LOAD_B, 32'h8000_0000, 16'd0);
        send_run();

        // Fill the second store past its depth: the extra term is dropped, every result of
        // the run reports overflow, and the pair at the shared exponent, the lowest kept, cancels.
        send(spa_pkg::ACT_LOAD_A, 32'd3, 16'd25);
        for (int k = 0; k <= spa_pkg::DEPTH; k++)
            send(spa_pkg::ACT_LOAD_B, (k == 15) ? -32'sd3 : rand_coef(), 16'(40 - k));
        send_run();

        random_start = items_sent;
        seq          = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            steady = (seq % 12 == 5);
            roll   = $urandom_range(0, 99);
            if (seq == 4 || seq == 40) begin
                // Long receiver hold while a large run is in flight and more loads wait.
                hold_req++;
                send_sum_case(12, 2, 1'b0);
                send_sum_case(6, -1, 1'b0);
            end else if (roll < 70) begin
                send_sum_case($urandom_range(0, ($urandom_range(0, 9) == 0) ? 20 : 6),
                              -1, 1'b0);
            end else if (roll < 77) begin
                send_sum_case($urandom_range(1, 5), 2, 1'b1);
            end else if (roll < 83) begin
                send_sum_case($urandom_range(16, 19), $urandom_range(0, 2), 1'b0);
            end else begin
                send_noise();
            end
            seq++;
        end
        steady = 1'b0;

        // Drain: wait until every predicted term has come back, then give the block time to
        // show any stray transaction before the verdict.
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
rtl/spa_pkg.sv
rtl/spa_store.sv
rtl/spa_ctrl.sv
rtl/sparse_polynomial_adder.sv
test/sparse_polynomial_adder_checker.sv
test/sparse_polynomial_adder_test.sv
